// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define MSFW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define MSFW_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hdl/msfw_pkg.sv =====
// ----------------------------------------------------------------------------
// msfw_pkg
// shared constants, register codes and control structs of the wait-time block
// ----------------------------------------------------------------------------
package msfw_pkg;

    localparam int MAX_SERVERS = 128;
    localparam int SRV_IDX_W   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int SRV_CNT_W   = $clog2(MAX_SERVERS + 1);

    localparam int TIME_W     = 32;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 16;
    localparam int DAY_W      = 17;
    localparam int NSRV_W     = 8;
    localparam int MIN_W      = 10;
    localparam int SVC_SEC_W  = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;

    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

    localparam logic [NSRV_W-1:0] RST_NUM_SERVERS = NSRV_W'(1);
    localparam logic [DAY_W-1:0]  RST_OPEN_TIME   = DAY_W'(8 * SECS_PER_HOUR);
    localparam logic [DAY_W-1:0]  RST_CUTOFF_TIME = DAY_W'(17 * SECS_PER_HOUR);
    localparam logic [MIN_W-1:0]  RST_SERVICE_CAP = MIN_W'(60);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_SERVERS = 4'd0,
        REG_OPEN_TIME   = 4'd1,
        REG_CUTOFF_TIME = 4'd2,
        REG_SERVICE_CAP = 4'd3
    } t_reg_idx;

    typedef struct packed {
        logic [NSRV_W-1:0] num_servers;
        logic [DAY_W-1:0]  open_time;
        logic [DAY_W-1:0]  cutoff_time;
        logic [MIN_W-1:0]  service_cap_minutes;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic classify;
        logic decide;
        logic scan_rd;
        logic update;
        logic accum;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic admit;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hdl/msfw_if.sv =====
// ----------------------------------------------------------------------------
// msfw channel interfaces
// customer item, result item and register write channels
// ----------------------------------------------------------------------------
interface msfw_item_if;
    logic       valid;
    logic       ready;
    logic [4:0] arrival_hour;
    logic [5:0] arrival_minute;
    logic [5:0] arrival_second;
    logic [9:0] service_minutes;
    logic       last_customer;

    modport source (output valid, arrival_hour, arrival_minute, arrival_second,
                    service_minutes, last_customer, input ready);
    modport sink   (input valid, arrival_hour, arrival_minute, arrival_second,
                    service_minutes, last_customer, output ready);
endinterface

interface msfw_result_if;
    logic        valid;
    logic        ready;
    logic        admitted;
    logic [31:0] wait_seconds;
    logic [47:0] total_wait;
    logic [15:0] admitted_count;
    logic        batch_done;

    modport source (output valid, admitted, wait_seconds, total_wait, admitted_count,
                    batch_done, input ready);
    modport sink   (input valid, admitted, wait_seconds, total_wait, admitted_count,
                    batch_done, output ready);
endinterface

interface msfw_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  reg_index;
    logic [16:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== hdl/msfw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// msfw_cfg_regs
// configuration register file, always ready, unknown indexes ignored
// ----------------------------------------------------------------------------
module msfw_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    msfw_cfg_if.sink       i_cfg,
    output msfw_pkg::t_cfg o_cfg
);
    import msfw_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_servers         <= RST_NUM_SERVERS;
            r_cfg.open_time           <= RST_OPEN_TIME;
            r_cfg.cutoff_time         <= RST_CUTOFF_TIME;
            r_cfg.service_cap_minutes <= RST_SERVICE_CAP;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.reg_index))
                REG_NUM_SERVERS: r_cfg.num_servers <= i_cfg.wdata[NSRV_W-1:0];
                REG_OPEN_TIME:   r_cfg.open_time <= i_cfg.wdata[DAY_W-1:0];
                REG_CUTOFF_TIME: r_cfg.cutoff_time <= i_cfg.wdata[DAY_W-1:0];
                REG_SERVICE_CAP: r_cfg.service_cap_minutes <= i_cfg.wdata[MIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hdl/msfw_ctrl.sv =====
// ----------------------------------------------------------------------------
// msfw_ctrl
// per-item sequencer: classify, decide, then scan, update and accumulate if admitted, report
// ----------------------------------------------------------------------------
module msfw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  msfw_pkg::t_dp_sts i_sts,
    output msfw_pkg::t_dp_cmd o_cmd
);
    import msfw_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_CLASSIFY = 8'b0000_0010,
        ST_DECIDE   = 8'b0000_0100,
        ST_SCAN     = 8'b0000_1000,
        ST_DRAIN    = 8'b0001_0000,
        ST_UPDATE   = 8'b0010_0000,
        ST_ACCUM    = 8'b0100_0000,
        ST_FINISH   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                o_cmd.classify = 1'b1;
                n_state        = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_sts.admit) begin
                    // first server read goes out right away
                    o_cmd.scan_rd = 1'b1;
                    n_state       = i_sts.scan_last ? ST_DRAIN : ST_SCAN;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_ACCUM;
            end
            ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/msfw_dp.sv =====
// ----------------------------------------------------------------------------
// msfw_dp
// server free-time memory, minimum scan, wait and total arithmetic, result reg
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msfw_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  msfw_pkg::t_cfg    i_cfg,
    input  msfw_pkg::t_dp_cmd i_cmd,
    output msfw_pkg::t_dp_sts o_sts,
    input  logic [4:0]        i_arrival_hour,
    input  logic [5:0]        i_arrival_minute,
    input  logic [5:0]        i_arrival_second,
    input  logic [9:0]        i_service_minutes,
    input  logic              i_last_customer,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_admitted,
    output logic [31:0]       o_wait_seconds,
    output logic [47:0]       o_total_wait,
    output logic [15:0]       o_admitted_count,
    output logic              o_batch_done
);
    import msfw_pkg::*;

    // captured item
    logic [4:0]           r_hour;
    logic [5:0]           r_minute;
    logic [5:0]           r_second;
    logic [MIN_W-1:0]     r_svc;
    logic                 r_last;

    // batch state
    logic                 r_fresh;
    logic [DAY_W-1:0]     r_open_lat;
    logic [MAX_SERVERS-1:0] r_vld;
    logic [TIME_W-1:0]    r_mem [MAX_SERVERS];
    logic [SUM_W-1:0]     r_wait_sum;
    logic [CNT_W-1:0]     r_cnt;

    // per-item work
    logic [DAY_W-1:0]     r_arrival;
    logic                 r_admit;
    logic [SVC_SEC_W-1:0] r_svc_sec;
    logic [SRV_IDX_W-1:0] r_idx;
    logic [TIME_W-1:0]    r_rd_data;
    logic                 r_rd_vld;
    logic [SRV_IDX_W-1:0] r_rd_idx;
    logic                 r_rd_first;
    logic                 r_rd_pend;
    logic [TIME_W-1:0]    r_best_val;
    logic [SRV_IDX_W-1:0] r_best_idx;
    logic [TIME_W-1:0]    r_wait;

    // result register
    logic                 r_o_valid;
    logic                 r_o_admitted;
    logic [TIME_W-1:0]    r_o_wait;
    logic [SUM_W-1:0]     r_o_total;
    logic [CNT_W-1:0]     r_o_cnt;
    logic                 r_o_done;

    logic [SRV_CNT_W-1:0] used;
    logic [DAY_W-1:0]     n_arrival;
    logic                 admit;
    logic [MIN_W-1:0]     svc_capped;
    logic [TIME_W-1:0]    cand;
    logic                 late;
    logic [TIME_W-1:0]    start;
    logic [TIME_W:0]      fin;
    logic [TIME_W-1:0]    fin_sat;
    logic [SUM_W:0]       sum_ext;

    // servers in use, zero acts as one
    always_comb begin
        if (i_cfg.num_servers == '0) begin
            used = SRV_CNT_W'(1);
        end else if (int'(i_cfg.num_servers) > MAX_SERVERS) begin
            used = SRV_CNT_W'(MAX_SERVERS);
        end else begin
            used = SRV_CNT_W'(i_cfg.num_servers);
        end
    end

    assign n_arrival  = DAY_W'(r_hour) * DAY_W'(SECS_PER_HOUR)
                      + DAY_W'(r_minute) * DAY_W'(SECS_PER_MIN) + DAY_W'(r_second);
    assign admit      = (r_arrival <= i_cfg.cutoff_time);
    assign svc_capped = (r_svc > i_cfg.service_cap_minutes) ? i_cfg.service_cap_minutes : r_svc;

    // a server not yet used in this batch is free at the opening time
    assign cand    = r_rd_vld ? r_rd_data : TIME_W'(r_open_lat);

    assign late    = (r_best_val > TIME_W'(r_arrival));
    assign start   = late ? r_best_val : TIME_W'(r_arrival);
    assign fin     = {1'b0, start} + (TIME_W + 1)'(r_svc_sec);
    assign fin_sat = fin[TIME_W] ? '1 : fin[TIME_W-1:0];
    assign sum_ext = {1'b0, r_wait_sum} + (SUM_W + 1)'(r_wait);

    assign o_sts.admit     = admit;
    assign o_sts.scan_last = (SRV_CNT_W'(r_idx) == used - SRV_CNT_W'(1));
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

    // free-time memory, one read or one write a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_mem[r_idx];
        end
        if (i_cmd.update) begin
            r_mem[r_best_idx] <= fin_sat;
        end
    end

    // payload and per-item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hour   <= i_arrival_hour;
            r_minute <= i_arrival_minute;
            r_second <= i_arrival_second;
            r_svc    <= i_service_minutes;
            r_last   <= i_last_customer;
            if (r_fresh) begin
                r_open_lat <= i_cfg.open_time;
            end
        end
        if (i_cmd.classify) begin
            r_arrival <= n_arrival;
            r_idx     <= '0;
            r_wait    <= '0;
        end
        if (i_cmd.decide) begin
            r_admit   <= admit;
            r_svc_sec <= SVC_SEC_W'(svc_capped) * SVC_SEC_W'(SECS_PER_MIN);
        end
        if (i_cmd.scan_rd) begin
            r_rd_vld   <= r_vld[r_idx];
            r_rd_idx   <= r_idx;
            r_rd_first <= (r_idx == '0);
            r_idx      <= r_idx + SRV_IDX_W'(1);
        end
        // strict compare keeps the lowest index among ties
        if (r_rd_pend && (r_rd_first || cand < r_best_val)) begin
            r_best_val <= cand;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.update) begin
            r_wait <= late ? (r_best_val - TIME_W'(r_arrival)) : '0;
        end
        if (i_cmd.out_load) begin
            r_o_admitted <= r_admit;
            r_o_wait     <= r_wait;
            r_o_total    <= r_wait_sum;
            r_o_cnt      <= r_cnt;
            r_o_done     <= r_last;
        end
    end

    // control and batch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh    <= 1'b1;
            r_vld      <= '0;
            r_wait_sum <= '0;
            r_cnt      <= '0;
            r_rd_pend  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.scan_rd;
            if (i_cmd.capture) begin
                r_fresh <= 1'b0;
            end
            if (i_cmd.update) begin
                r_vld[r_best_idx] <= 1'b1;
            end
            if (i_cmd.accum) begin
                r_wait_sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                if (r_cnt != '1) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
                // last customer closes the batch once its result is out
                if (r_last) begin
                    r_fresh    <= 1'b1;
                    r_vld      <= '0;
                    r_wait_sum <= '0;
                    r_cnt      <= '0;
                end
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_admitted       = r_o_admitted;
    assign o_wait_seconds   = r_o_wait;
    assign o_total_wait     = r_o_total;
    assign o_admitted_count = r_o_cnt;
    assign o_batch_done     = r_o_done;

    `MSFW_ASSERT_NEXT(a_cnt_step, i_cmd.accum, (r_cnt == $past(r_cnt) + CNT_W'(1)) || (r_cnt == '1), "admitted count did not step")
    `MSFW_ASSERT(a_best_in_range, i_cmd.update |-> (SRV_CNT_W'(r_best_idx) < used), "chosen server outside the servers in use")
    `MSFW_ASSERT(a_reject_no_wait, (r_o_valid && !r_o_admitted) |-> (r_o_wait == '0), "rejected item reports a wait")

endmodule

// ===== hdl/multi_server_fcfs_wait.sv =====
// ----------------------------------------------------------------------------
// multi_server_fcfs_wait
// first-come first-served wait time over a pool of service windows
// ----------------------------------------------------------------------------
// Customers come in arrival order, one item each, and every item gives exactly
// one result. A rejected customer (arrival after cutoff_time) goes through
// classify and decide to the result register. An admitted customer also goes
// through a server scan, with num_servers clamped to 1..128: the free times of
// the servers sit in a 128-entry memory with one read port, and the search for
// the server that frees soonest reads it one entry a cycle. The block takes one
// customer at a time; the result register lets the next customer in while the
// previous result still waits. Per-server valid bits stand in for the
// batch-start load of the opening time, so there is no clearing pass after
// reset or after the last customer. Configuration writes are taken at any time
// and are meant for idle periods; open_time is sampled by the first customer
// of each batch.
// ----------------------------------------------------------------------------
module multi_server_fcfs_wait (
    input  logic          i_clk,
    input  logic          i_rst_n,
    msfw_item_if.sink     i_item,
    msfw_result_if.source o_result,
    msfw_cfg_if.sink      i_cfg
);
    import msfw_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // register file, written through the config channel
    msfw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // sequencer, owns the input handshake
    msfw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // memory, scan, arithmetic and result register
    msfw_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_arrival_hour    (i_item.arrival_hour),
        .i_arrival_minute  (i_item.arrival_minute),
        .i_arrival_second  (i_item.arrival_second),
        .i_service_minutes (i_item.service_minutes),
        .i_last_customer   (i_item.last_customer),
        .i_out_ready       (o_result.ready),
        .o_out_valid       (o_result.valid),
        .o_admitted        (o_result.admitted),
        .o_wait_seconds    (o_result.wait_seconds),
        .o_total_wait      (o_result.total_wait),
        .o_admitted_count  (o_result.admitted_count),
        .o_batch_done      (o_result.batch_done)
    );

endmodule
